@@ design/sprite_animation_sequencer_defines.svh @@
// Assertion macros used by the sprite animation sequencer.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define SAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define SAS_ASSERT_IMP(lbl, ante, cons, msg)
`define SAS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/sas_pkg.sv @@
`default_nettype none
package sas_pkg;
  localparam int ENTITIES_DEF  = 1024;
  localparam int ANIM_DEFS_DEF = 256;

  localparam logic [15:0] MAX_DT_RESET = 16'd3277;
  localparam logic [23:0] DUR_MIN      = 24'd6;
  localparam logic [15:0] SPEED_ONE    = 16'd256;

  localparam int DIV_DW = 33;
  localparam int DIV_SW = 24;

  localparam logic [3:0] ACT_DEFINE    = 4'd0;
  localparam logic [3:0] ACT_PLAY      = 4'd1;
  localparam logic [3:0] ACT_STOP      = 4'd2;
  localparam logic [3:0] ACT_PAUSE     = 4'd3;
  localparam logic [3:0] ACT_RESUME    = 4'd4;
  localparam logic [3:0] ACT_SET_FRAME = 4'd5;
  localparam logic [3:0] ACT_SET_SPEED = 4'd6;
  localparam logic [3:0] ACT_SET_LOOP  = 4'd7;
  localparam logic [3:0] ACT_TICK      = 4'd8;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_PLAYING = 2'd2;

  typedef struct packed {
    logic [7:0]  anim;
    logic [15:0] frame;
    logic [31:0] timer;
    logic [15:0] speed;
    logic [23:0] duration;
    logic [15:0] count;
    logic [15:0] start;
    logic        pause;
    logic        loop;
    logic        fin;
  } ent_t;

  typedef struct packed {
    logic [23:0] duration;
    logic [15:0] count;
    logic [15:0] start;
    logic        loop;
  } def_t;
endpackage
`default_nettype wire

@@ design/sas_ram.sv @@
`default_nettype none
module sas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ design/sas_div.sv @@
`default_nettype none
module sas_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sas_pkg::DIV_DW-1:0] dividend_i,
  input  wire logic [sas_pkg::DIV_SW-1:0] divisor_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic      [sas_pkg::DIV_DW-1:0] quot_o,
  output logic      [sas_pkg::DIV_SW-1:0] rem_o
);
  localparam int CW = $clog2(sas_pkg::DIV_DW + 1);

  logic [CW-1:0]                cnt_q;
  logic [sas_pkg::DIV_SW-1:0]   div_q;
  logic [sas_pkg::DIV_SW-1:0]   rem_q;
  logic [sas_pkg::DIV_DW-1:0]   quo_q;
  logic [sas_pkg::DIV_SW:0]     sh;
  logic [sas_pkg::DIV_SW:0]     diff;
  logic                         ge;

  always_comb begin
    sh   = {rem_q, quo_q[sas_pkg::DIV_DW-1]};
    ge   = sh >= {1'b0, div_q};
    diff = sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_o <= 1'b0;
      done_o <= 1'b0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= CW'(sas_pkg::DIV_DW);
      busy_o <= 1'b1;
      done_o <= 1'b0;
      div_q  <= divisor_i;
      rem_q  <= '0;
      quo_q  <= dividend_i;
    end else if (busy_o) begin
      rem_q <= ge ? diff[sas_pkg::DIV_SW-1:0] : sh[sas_pkg::DIV_SW-1:0];
      quo_q <= {quo_q[sas_pkg::DIV_DW-2:0], ge};
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_o <= 1'b0;
        done_o <= 1'b1;
      end
    end else begin
      done_o <= 1'b0;
    end
  end

  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

@@ design/sprite_animation_sequencer.sv @@
`default_nettype none
`include "sprite_animation_sequencer_defines.svh"
// Sprite animation sequencer: one command per input transfer, one result transfer per command.
// Entity and descriptor state live in single-port-read synchronous RAMs; each command is a read,
// a modify and a write back, and the next command is taken only once the write back is done.
// After reset the entity RAM is cleared, one entry per cycle, through all ENTITIES entries (1024 by
// default), during which no command is taken. Define, play and the other entity commands pass through
// the execute and done states; a tick that advances frames also runs the bit-serial divider for
// timer / duration, and a looping tick runs it again for the loop frame modulo count.
module sprite_animation_sequencer #(
  parameter int ENTITIES  = sas_pkg::ENTITIES_DEF,
  parameter int ANIM_DEFS = sas_pkg::ANIM_DEFS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  action_i,
  input  wire logic [9:0]  entity_i,
  input  wire logic [7:0]  anim_id_i,
  input  wire logic        force_reset_i,
  input  wire logic [15:0] frame_index_i,
  input  wire logic [15:0] speed_i,
  input  wire logic        loop_enable_i,
  input  wire logic [15:0] delta_time_i,
  input  wire logic [23:0] frame_duration_i,
  input  wire logic [15:0] frame_total_i,
  input  wire logic [15:0] start_sprite_i,
  input  wire logic [3:0]  entity_status_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] sprite_id_o,
  output logic             sprite_write_o,
  output logic      [15:0] current_frame_o,
  output logic             finished_o,
  output logic      [1:0]  status_o
);
  localparam int EW = ENTITIES > 1 ? $clog2(ENTITIES) : 1;
  localparam int AW = ANIM_DEFS > 1 ? $clog2(ANIM_DEFS) : 1;
  localparam int EB = $bits(sas_pkg::ent_t);
  localparam int DB = $bits(sas_pkg::def_t);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_MUL, S_DIV1, S_DIV2, S_KMUL, S_DONE
  } state_e;

  state_e         state_q;
  logic [15:0]    maxdt_q;
  logic [EW-1:0]  clr_q;
  logic [EW-1:0]  eidx_q;
  logic [AW-1:0]  aidx_q;
  logic           eok_q;
  logic           aok_q;
  logic [3:0]     act_q;
  logic [7:0]     a_q;
  logic           force_q;
  logic [15:0]    fidx_q;
  logic [15:0]    spd_q;
  logic           lp_q;
  logic [15:0]    dt_q;
  logic [23:0]    dur_q;
  logic [15:0]    cnt_q;
  logic [15:0]    start_q;
  logic [3:0]     st_q;
  sas_pkg::ent_t  rec_q;
  logic           have_q;
  logic           wr_q;
  logic           we_q;
  logic [1:0]     status_q;
  logic [40:0]    prod_q;

  logic [31:0]    ent32;
  logic [31:0]    anim32;
  logic           in_acc;
  logic           out_free;
  logic           done_fire;
  logic           ent_we;
  logic [EB-1:0]  ent_rbits;
  logic [DB-1:0]  def_rbits;
  sas_pkg::ent_t  ent_rd;
  sas_pkg::def_t  def_rd;
  sas_pkg::def_t  def_wr;
  logic           def_we;

  logic [15:0]    dtc;
  logic [32:0]    tsum;
  logic [31:0]    t32;
  logic [15:0]    f1;
  logic [15:0]    f1w;
  logic [16:0]    kval;
  logic           q_ge_k;

  logic                        div_start;
  logic [sas_pkg::DIV_DW-1:0]  div_dvd;
  logic [sas_pkg::DIV_SW-1:0]  div_dsr;
  logic                        div_busy;
  logic                        div_done;
  logic [sas_pkg::DIV_DW-1:0]  div_quot;
  logic [sas_pkg::DIV_SW-1:0]  div_rem;

  assign ent32      = 32'(entity_i);
  assign anim32     = 32'(anim_id_i);
  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;
  assign done_fire  = (state_q == S_DONE) && out_free;
  assign ent_we     = (state_q == S_CLEAR) || (done_fire && we_q);
  assign ent_rd     = sas_pkg::ent_t'(ent_rbits);
  assign def_rd     = sas_pkg::def_t'(def_rbits);
  assign def_we     = (state_q == S_EXEC) && (act_q == sas_pkg::ACT_DEFINE) && aok_q;
  assign def_wr     = '{duration: dur_q, count: cnt_q, start: start_q, loop: lp_q};

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, maxdt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxdt_q <= sas_pkg::MAX_DT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      maxdt_q <= pwdata[15:0];
    end
  end

  sas_ram #(.WIDTH(EB), .DEPTH(ENTITIES)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (state_q == S_CLEAR ? clr_q : eidx_q),
    .wdata_i (state_q == S_CLEAR ? EB'(0) : EB'(rec_q)),
    .re_i    (in_acc),
    .raddr_i (ent32[EW-1:0]),
    .rdata_o (ent_rbits)
  );

  sas_ram #(.WIDTH(DB), .DEPTH(ANIM_DEFS)) u_def_ram (
    .clk_i   (clk_i),
    .we_i    (def_we),
    .waddr_i (aidx_q),
    .wdata_i (DB'(def_wr)),
    .re_i    (in_acc),
    .raddr_i (anim32[AW-1:0]),
    .rdata_o (def_rbits)
  );

  always_comb begin
    dtc  = (dt_q > maxdt_q) ? maxdt_q : dt_q;
    tsum = {1'b0, rec_q.timer} + 33'(prod_q[31:8]);
    t32  = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
    f1   = rec_q.frame + 16'd1;
    f1w  = (f1 >= rec_q.count) ? 16'd0 : f1;
    if (rec_q.count == 16'd0) begin
      kval = 17'd1;
    end else if (rec_q.frame < rec_q.count) begin
      kval = {1'b0, rec_q.count} - {1'b0, rec_q.frame};
    end else if (rec_q.frame != 16'hFFFF) begin
      kval = 17'd1;
    end else begin
      kval = {1'b0, rec_q.count} + 17'd1;
    end
    q_ge_k = div_quot >= 33'(kval);
    div_start = ((state_q == S_MUL) && (t32 >= 32'(rec_q.duration))) ||
                ((state_q == S_DIV1) && div_done && rec_q.loop && (rec_q.count != 16'd0));
    div_dvd = (state_q == S_MUL) ? {1'b0, t32} : 33'(f1w) + div_quot - 33'd1;
    div_dsr = (state_q == S_MUL) ? rec_q.duration : 24'(rec_q.count);
  end

  sas_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      clr_q           <= '0;
      eidx_q          <= '0;
      aidx_q          <= '0;
      eok_q           <= 1'b0;
      aok_q           <= 1'b0;
      act_q           <= '0;
      a_q             <= '0;
      force_q         <= 1'b0;
      fidx_q          <= '0;
      spd_q           <= '0;
      lp_q            <= 1'b0;
      dt_q            <= '0;
      dur_q           <= '0;
      cnt_q           <= '0;
      start_q         <= '0;
      st_q            <= '0;
      rec_q           <= '0;
      have_q          <= 1'b0;
      wr_q            <= 1'b0;
      we_q            <= 1'b0;
      status_q        <= sas_pkg::ST_APPLIED;
      prod_q          <= '0;
      out_valid_o     <= 1'b0;
      sprite_id_o     <= '0;
      sprite_write_o  <= 1'b0;
      current_frame_o <= '0;
      finished_o      <= 1'b0;
      status_o        <= sas_pkg::ST_APPLIED;
    end else begin
      if (done_fire) begin
        out_valid_o     <= 1'b1;
        sprite_id_o     <= wr_q ? rec_q.start + rec_q.frame : 16'd0;
        sprite_write_o  <= wr_q;
        current_frame_o <= have_q ? rec_q.frame : 16'd0;
        finished_o      <= have_q && rec_q.fin;
        status_o        <= status_q;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + EW'(1);
          if (clr_q == EW'(ENTITIES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            eidx_q  <= ent32[EW-1:0];
            eok_q   <= ent32 < 32'(ENTITIES);
            aidx_q  <= anim32[AW-1:0];
            aok_q   <= anim32 < 32'(ANIM_DEFS);
            a_q     <= anim_id_i;
            force_q <= force_reset_i;
            fidx_q  <= frame_index_i;
            spd_q   <= speed_i;
            lp_q    <= loop_enable_i;
            dt_q    <= delta_time_i;
            dur_q   <= frame_duration_i;
            cnt_q   <= frame_total_i;
            start_q <= start_sprite_i;
            st_q    <= entity_status_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          rec_q    <= ent_rd;
          have_q   <= 1'b0;
          wr_q     <= 1'b0;
          we_q     <= 1'b0;
          status_q <= sas_pkg::ST_APPLIED;
          state_q  <= S_DONE;
          if (act_q == sas_pkg::ACT_DEFINE) begin
            if (!aok_q) begin
              status_q <= sas_pkg::ST_INVALID;
            end
          end else if (act_q > sas_pkg::ACT_TICK || !eok_q) begin
            status_q <= sas_pkg::ST_INVALID;
          end else if (act_q == sas_pkg::ACT_TICK) begin
            have_q <= 1'b1;
            if (!st_q[1] || !st_q[2] || ent_rd.pause) begin
              status_q <= sas_pkg::ST_INVALID;
            end else if (ent_rd.fin) begin
              wr_q <= st_q[3];
            end else if (ent_rd.duration <= sas_pkg::DUR_MIN) begin
              rec_q.fin <= 1'b1;
              we_q      <= 1'b1;
            end else if (ent_rd.speed != 16'd0) begin
              prod_q  <= 41'(32'(dtc) * 32'(ent_rd.speed));
              we_q    <= 1'b1;
              wr_q    <= st_q[3];
              state_q <= S_MUL;
            end
          end else begin
            have_q <= 1'b1;
            if (!st_q[0] || !st_q[1]) begin
              status_q <= sas_pkg::ST_INVALID;
            end else begin
              we_q <= 1'b1;
              case (act_q)
                sas_pkg::ACT_PLAY: begin
                  if (!aok_q) begin
                    status_q <= sas_pkg::ST_INVALID;
                    we_q     <= 1'b0;
                  end else if (!force_q && ent_rd.anim == a_q && !ent_rd.fin) begin
                    status_q <= sas_pkg::ST_PLAYING;
                    we_q     <= 1'b0;
                  end else begin
                    rec_q.duration <= def_rd.duration;
                    rec_q.count    <= def_rd.count;
                    rec_q.start    <= def_rd.start;
                    rec_q.loop     <= def_rd.loop;
                    rec_q.fin      <= 1'b0;
                    rec_q.anim     <= a_q;
                    rec_q.frame    <= '0;
                    rec_q.timer    <= '0;
                    rec_q.speed    <= sas_pkg::SPEED_ONE;
                    wr_q           <= 1'b1;
                  end
                end
                sas_pkg::ACT_STOP: begin
                  rec_q.fin   <= 1'b1;
                  rec_q.timer <= '0;
                  rec_q.frame <= '0;
                end
                sas_pkg::ACT_PAUSE: begin
                  rec_q.pause <= 1'b1;
                end
                sas_pkg::ACT_RESUME: begin
                  rec_q.pause <= 1'b0;
                end
                sas_pkg::ACT_SET_FRAME: begin
                  rec_q.timer <= '0;
                  if (ent_rd.count == 16'd0) begin
                    rec_q.frame <= '0;
                    rec_q.fin   <= 1'b1;
                  end else begin
                    rec_q.frame <= (fidx_q >= ent_rd.count) ? ent_rd.count - 16'd1 : fidx_q;
                    rec_q.fin   <= 1'b0;
                  end
                end
                sas_pkg::ACT_SET_SPEED: begin
                  rec_q.speed <= spd_q;
                end
                default: begin
                  rec_q.loop <= lp_q;
                  if (lp_q) begin
                    rec_q.fin <= 1'b0;
                  end
                end
              endcase
            end
          end
        end
        S_MUL: begin
          rec_q.timer <= t32;
          state_q     <= (t32 >= 32'(rec_q.duration)) ? S_DIV1 : S_DONE;
        end
        S_DIV1: begin
          if (div_done) begin
            if (rec_q.loop) begin
              rec_q.timer <= 32'(div_rem);
              if (rec_q.count == 16'd0) begin
                rec_q.frame <= '0;
                state_q     <= S_DONE;
              end else begin
                state_q <= S_DIV2;
              end
            end else if (q_ge_k) begin
              prod_q  <= 41'(kval) * 41'(rec_q.duration);
              state_q <= S_KMUL;
            end else begin
              rec_q.timer <= 32'(div_rem);
              rec_q.frame <= rec_q.frame + div_quot[15:0];
              state_q     <= S_DONE;
            end
          end
        end
        S_DIV2: begin
          if (div_done) begin
            rec_q.frame <= div_rem[15:0];
            state_q     <= S_DONE;
          end
        end
        S_KMUL: begin
          rec_q.timer <= rec_q.timer - prod_q[31:0];
          rec_q.frame <= rec_q.count - 16'd1;
          rec_q.fin   <= 1'b1;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `SAS_ASSERT_IMP(a_div_start_free, div_start, !div_busy, "divider started while busy")
  `SAS_ASSERT_IMP(a_ent_we_state, ent_we, state_q == S_CLEAR || state_q == S_DONE, "entity write out of place")
  `SAS_ASSERT_NXT(a_accept_exec, in_valid_i && !in_stall_o, state_q == S_EXEC, "accepted command not executed")
endmodule
`default_nettype wire

@@ verif/sprite_animation_sequencer_tb.sv @@
`default_nettype none
module sprite_animation_sequencer_tb;

  localparam logic [2:0] REG_MAX_DT_ADDR = 3'd0;

  typedef struct packed {
    logic [3:0]  action;
    logic [9:0]  entity;
    logic [7:0]  anim_id;
    logic        force_reset;
    logic [15:0] frame_index;
    logic [15:0] speed;
    logic        loop_enable;
    logic [15:0] delta_time;
    logic [23:0] frame_duration;
    logic [15:0] frame_total;
    logic [15:0] start_sprite;
    logic [3:0]  entity_status;
  } cmd_t;

  typedef struct packed {
    logic [15:0] sprite_id;
    logic        sprite_write;
    logic [15:0] current_frame;
    logic        finished;
    logic [1:0]  status;
  } sprite_result_t;

  class anim_scoreboard;
    logic [23:0] def_dur [sas_pkg::ANIM_DEFS_DEF];
    logic [15:0] def_cnt [sas_pkg::ANIM_DEFS_DEF];
    logic [15:0] def_spr [sas_pkg::ANIM_DEFS_DEF];
    logic        def_lp  [sas_pkg::ANIM_DEFS_DEF];
    logic [7:0]  e_anim  [sas_pkg::ENTITIES_DEF];
    logic [15:0] e_frame [sas_pkg::ENTITIES_DEF];
    logic [31:0] e_timer [sas_pkg::ENTITIES_DEF];
    logic [15:0] e_speed [sas_pkg::ENTITIES_DEF];
    logic [23:0] e_dur   [sas_pkg::ENTITIES_DEF];
    logic [15:0] e_cnt   [sas_pkg::ENTITIES_DEF];
    logic [15:0] e_spr   [sas_pkg::ENTITIES_DEF];
    logic        e_fin   [sas_pkg::ENTITIES_DEF];
    logic        e_loop  [sas_pkg::ENTITIES_DEF];
    logic        e_pause [sas_pkg::ENTITIES_DEF];
    logic [15:0] max_dt;
    sprite_result_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < sas_pkg::ENTITIES_DEF; i++) begin
        e_anim[i] = 0; e_frame[i] = 0; e_timer[i] = 0; e_speed[i] = 0;
        e_dur[i] = 0; e_cnt[i] = 0; e_spr[i] = 0;
        e_fin[i] = 0; e_loop[i] = 0; e_pause[i] = 0;
      end
      max_dt = sas_pkg::MAX_DT_RESET;
      errors = 0;
    endfunction

    function void advance_frames(int e, longint unsigned q);
      longint unsigned d, f, c, k, f1;
      d = e_dur[e]; f = e_frame[e]; c = e_cnt[e];
      if (e_loop[e]) begin
        f1 = (f + 1) & 64'hFFFF;
        e_timer[e] = 32'(e_timer[e] % d);
        if (f1 >= c) f1 = 0;
        e_frame[e] = (c == 0) ? 16'd0 : 16'((f1 + (q - 1)) % c);
        return;
      end
      if (c == 0) k = 1;
      else if (f < c) k = c - f;
      else if (f < 64'hFFFF) k = 1;
      else k = c + 1;
      if (q >= k) begin
        e_timer[e] = 32'(e_timer[e] - k * d);
        e_frame[e] = 16'(c + 64'hFFFF);
        e_fin[e] = 1;
      end else begin
        e_timer[e] = 32'(e_timer[e] - q * d);
        e_frame[e] = 16'(f + q);
      end
    endfunction

    function void note(cmd_t c);
      sprite_result_t r;
      int e;
      logic [15:0] dt;
      longint unsigned t;
      r = '0;
      e = c.entity;
      r.status = sas_pkg::ST_APPLIED;
      if (c.action == sas_pkg::ACT_DEFINE) begin
        def_dur[c.anim_id] = c.frame_duration;
        def_cnt[c.anim_id] = c.frame_total;
        def_spr[c.anim_id] = c.start_sprite;
        def_lp[c.anim_id] = c.loop_enable;
      end else if (c.action > sas_pkg::ACT_TICK) begin
        r.status = sas_pkg::ST_INVALID;
      end else begin
        if (c.action == sas_pkg::ACT_TICK) begin
          if (!c.entity_status[1] || !c.entity_status[2] || e_pause[e]) begin
            r.status = sas_pkg::ST_INVALID;
          end else if (e_fin[e]) begin
            if (c.entity_status[3]) begin
              r.sprite_write = 1; r.sprite_id = e_spr[e] + e_frame[e];
            end
          end else if (e_dur[e] <= sas_pkg::DUR_MIN) begin
            e_fin[e] = 1;
          end else if (e_speed[e] != 0) begin
            dt = (c.delta_time > max_dt) ? max_dt : c.delta_time;
            t = longint'(e_timer[e]) + ((longint'(dt) * longint'(e_speed[e])) >> 8);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            e_timer[e] = 32'(t);
            if (t >= e_dur[e]) advance_frames(e, t / e_dur[e]);
            if (c.entity_status[3]) begin
              r.sprite_write = 1; r.sprite_id = e_spr[e] + e_frame[e];
            end
          end
        end else if (!c.entity_status[0] || !c.entity_status[1]) begin
          r.status = sas_pkg::ST_INVALID;
        end else begin
          case (c.action)
            sas_pkg::ACT_PLAY: begin
              if (!c.force_reset && e_anim[e] == c.anim_id && !e_fin[e]) begin
                r.status = sas_pkg::ST_PLAYING;
              end else begin
                e_dur[e] = def_dur[c.anim_id];
                e_cnt[e] = def_cnt[c.anim_id];
                e_spr[e] = def_spr[c.anim_id];
                e_loop[e] = def_lp[c.anim_id];
                e_fin[e] = 0;
                e_anim[e] = c.anim_id;
                e_frame[e] = 0;
                e_timer[e] = 0;
                e_speed[e] = sas_pkg::SPEED_ONE;
                r.sprite_write = 1;
                r.sprite_id = def_spr[c.anim_id];
              end
            end
            sas_pkg::ACT_STOP: begin
              e_fin[e] = 1; e_timer[e] = 0; e_frame[e] = 0;
            end
            sas_pkg::ACT_PAUSE: e_pause[e] = 1;
            sas_pkg::ACT_RESUME: e_pause[e] = 0;
            sas_pkg::ACT_SET_FRAME: begin
              e_timer[e] = 0;
              if (e_cnt[e] == 0) begin
                e_frame[e] = 0; e_fin[e] = 1;
              end else begin
                e_frame[e] = (c.frame_index >= e_cnt[e]) ? e_cnt[e] - 16'd1 : c.frame_index;
                e_fin[e] = 0;
              end
            end
            sas_pkg::ACT_SET_SPEED: e_speed[e] = c.speed;
            default: begin
              if (c.loop_enable) begin
                e_loop[e] = 1; e_fin[e] = 0;
              end else begin
                e_loop[e] = 0;
              end
            end
          endcase
        end
        r.current_frame = e_frame[e];
        r.finished = e_fin[e];
      end
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check(sprite_result_t got);
      sprite_result_t w;
      if (expected_q.size() == 0) begin
        report("commands outstanding", 16'd0, 16'd1);
        return;
      end
      w = expected_q.pop_front();
      if (got.sprite_id != w.sprite_id) report("sprite_id", got.sprite_id, w.sprite_id);
      if (got.sprite_write != w.sprite_write)
        report("sprite_write", 16'(got.sprite_write), 16'(w.sprite_write));
      if (got.current_frame != w.current_frame)
        report("current_frame", got.current_frame, w.current_frame);
      if (got.finished != w.finished) report("finished", 16'(got.finished), 16'(w.finished));
      if (got.status != w.status) report("status", 16'(got.status), 16'(w.status));
    endtask
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  cmd_t        cmd_q = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  sprite_result_t res;
  logic        quiet = 0;

  anim_scoreboard sb;
  logic        defined [sas_pkg::ANIM_DEFS_DEF];
  logic [9:0]  pool [8] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd341, 10'd512, 10'd682, 10'd1023};

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  sprite_animation_sequencer u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .action_i(cmd_q.action), .entity_i(cmd_q.entity), .anim_id_i(cmd_q.anim_id),
    .force_reset_i(cmd_q.force_reset), .frame_index_i(cmd_q.frame_index),
    .speed_i(cmd_q.speed), .loop_enable_i(cmd_q.loop_enable),
    .delta_time_i(cmd_q.delta_time), .frame_duration_i(cmd_q.frame_duration),
    .frame_total_i(cmd_q.frame_total), .start_sprite_i(cmd_q.start_sprite),
    .entity_status_i(cmd_q.entity_status),
    .out_valid_o, .out_stall_i,
    .sprite_id_o(res.sprite_id), .sprite_write_o(res.sprite_write),
    .current_frame_o(res.current_frame), .finished_o(res.finished), .status_o(res.status)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(res);
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 13);
  end

  task automatic send(cmd_t c);
    while (!quiet && $urandom_range(99) < 13) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    cmd_q <= c;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(c);
    if (c.action == sas_pkg::ACT_DEFINE) defined[c.anim_id] = 1;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_max_dt(logic [15:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_MAX_DT_ADDR; pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.max_dt = v;
    @(posedge clk_i);
  endtask

  function automatic cmd_t mk(logic [3:0] act, logic [9:0] ent);
    cmd_t c;
    c = '0;
    c.action = act;
    c.entity = ent;
    c.entity_status = 4'hF;
    return c;
  endfunction

  function automatic cmd_t mk_define(logic [7:0] a, logic [23:0] d, logic [15:0] n,
                                     logic [15:0] s, logic lp);
    cmd_t c;
    c = mk(sas_pkg::ACT_DEFINE, 10'd0);
    c.anim_id = a; c.frame_duration = d; c.frame_total = n;
    c.start_sprite = s; c.loop_enable = lp;
    return c;
  endfunction

  function automatic cmd_t mk_play(logic [9:0] e, logic [7:0] a, logic f);
    cmd_t c;
    c = mk(sas_pkg::ACT_PLAY, e);
    c.anim_id = a; c.force_reset = f;
    return c;
  endfunction

  function automatic cmd_t mk_tick(logic [9:0] e, logic [15:0] dt);
    cmd_t c;
    c = mk(sas_pkg::ACT_TICK, e);
    c.delta_time = dt;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int p;
    int a;
    c.action = sas_pkg::ACT_TICK;
    c.entity = ($urandom_range(9) == 0) ? 10'($urandom) : pool[$urandom_range(7)];
    c.anim_id = 8'($urandom);
    c.force_reset = 1'($urandom);
    c.frame_index = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12));
    p = $urandom_range(3);
    c.speed = (p == 0) ? 16'($urandom) : (p == 1) ? sas_pkg::SPEED_ONE
            : 16'($urandom_range(2048));
    if ($urandom_range(15) == 0) c.speed = 0;
    c.loop_enable = 1'($urandom);
    c.delta_time = 16'($urandom);
    p = $urandom_range(9);
    c.frame_duration = (p == 0) ? 24'($urandom) : (p == 1) ? 24'($urandom_range(6))
                     : 24'($urandom_range(4000, 7));
    c.frame_total = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(10));
    c.start_sprite = 16'($urandom);
    c.entity_status = ($urandom_range(4) == 0) ? 4'($urandom) : 4'hF;
    p = $urandom_range(99);
    if (p < 8) c.action = sas_pkg::ACT_DEFINE;
    else if (p < 22) c.action = sas_pkg::ACT_PLAY;
    else if (p < 25) c.action = sas_pkg::ACT_STOP;
    else if (p < 28) c.action = sas_pkg::ACT_PAUSE;
    else if (p < 32) c.action = sas_pkg::ACT_RESUME;
    else if (p < 36) c.action = sas_pkg::ACT_SET_FRAME;
    else if (p < 40) c.action = sas_pkg::ACT_SET_SPEED;
    else if (p < 44) c.action = sas_pkg::ACT_SET_LOOP;
    else if (p < 46) c.action = 4'($urandom_range(15, 9));
    if (c.action == sas_pkg::ACT_PLAY) begin
      a = $urandom_range(255);
      while (!defined[a]) a = (a + 1) % sas_pkg::ANIM_DEFS_DEF;
      c.anim_id = 8'(a);
    end
    return c;
  endfunction

  initial begin
    cmd_t c;
    logic [15:0] dt_setting [4];
    sb = new();
    for (int i = 0; i < sas_pkg::ANIM_DEFS_DEF; i++) defined[i] = 0;
    dt_setting[0] = 16'd0;
    dt_setting[1] = 16'hFFFF;
    dt_setting[2] = 16'($urandom);
    dt_setting[3] = sas_pkg::MAX_DT_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(mk_define(8'd0, 24'd100, 16'd4, 16'd10, 1'b0));
    send(mk_define(8'd1, 24'd50, 16'd3, 16'hFFFE, 1'b1));
    send(mk_define(8'd2, 24'd5, 16'd8, 16'd7, 1'b0));
    send(mk_define(8'd255, 24'hFFFFFF, 16'd0, 16'hFFFF, 1'b1));
    send(mk_define(8'd170, 24'd7, 16'hFFFF, 16'd0, 1'b0));
    send(mk_play(10'd0, 8'd0, 1'b0));
    send(mk_play(10'd0, 8'd0, 1'b0));
    send(mk_play(10'd0, 8'd0, 1'b1));
    send(mk_tick(10'd0, 16'hFFFF));
    c = mk(sas_pkg::ACT_SET_SPEED, 10'd0); c.speed = 16'hFFFF; send(c);
    send(mk_tick(10'd0, 16'd3000));
    send(mk_tick(10'd0, 16'd3000));
    c = mk(sas_pkg::ACT_PAUSE, 10'd0); send(c);
    send(mk_tick(10'd0, 16'd100));
    c = mk(sas_pkg::ACT_RESUME, 10'd0); send(c);
    c = mk(sas_pkg::ACT_SET_FRAME, 10'd0); c.frame_index = 16'hFFFF; send(c);
    c = mk(sas_pkg::ACT_SET_LOOP, 10'd0); c.loop_enable = 1; send(c);
    c = mk(sas_pkg::ACT_STOP, 10'd0); send(c);
    send(mk_tick(10'd0, 16'd10));
    send(mk_play(10'd1, 8'd1, 1'b0));
    c = mk_tick(10'd1, 16'd2000); c.entity_status = 4'b1110; send(c);
    send(mk_play(10'd2, 8'd2, 1'b0));
    send(mk_tick(10'd2, 16'd1));
    send(mk_play(10'd1023, 8'd255, 1'b0));
    c = mk(sas_pkg::ACT_SET_FRAME, 10'd1023); c.frame_index = 16'd3; send(c);
    c = mk(sas_pkg::ACT_SET_SPEED, 10'd1); c.speed = 0; c.entity_status = 4'b0001; send(c);
    c = mk(4'd15, 10'd3); send(c);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_max_dt(dt_setting[ph]);
      for (int i = 0; i < 138; i++) begin
        quiet <= (ph == 2 && i >= 30 && i < 90);
        if (ph == 1 && i == 70) begin
          in_valid_i <= 0;
          while (sb.expected_q.size() != 0) @(posedge clk_i);
        end
        send(random_cmd());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("sprite_animation_sequencer test passed");
    end else begin
      $display("sprite_animation_sequencer test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("sprite_animation_sequencer test failed");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+design
design/sas_pkg.sv
design/sas_ram.sv
design/sas_div.sv
design/sprite_animation_sequencer.sv
verif/sprite_animation_sequencer_tb.sv
